/* sv/prq_pkg.sv */
// Shared types, constants and helpers for the priority request queue.
`timescale 1ns / 1ps

package prq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int ENTRY_W     = 32;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CNT_W-1:0]  count_type;

   localparam logic FUNC_PUT = 1'b0;
   localparam logic FUNC_GET = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2,
      STATUS_NONE  = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0]  prio;
      logic [7:0]  client_task;
      logic [15:0] handle;
   } entry_type;

   typedef struct packed {
      logic        func;
      logic [15:0] req_handle;
      logic [7:0]  client_task;
      logic [7:0]  priority_req;
   } req_item_type;

   typedef struct packed {
      status_type  status;
      logic        wake_server;
      logic [7:0]  wake_task;
      logic [15:0] out_req_handle;
      logic [7:0]  out_task;
      logic [7:0]  out_priority;
      logic [4:0]  remaining;
   } rsp_item_type;

   // Low five bits of a count, zero-extended when the count is narrower.
   function automatic logic [4:0] to_remaining(input count_type cnt);
      logic [CNT_W+4:0] ext;
      ext = {5'b0, cnt};
      return ext[4:0];
   endfunction

endpackage

/* sv/priority_request_queue_core.sv */
// Top level of the priority request queue: control sequencer around the entry RAM.
`timescale 1ns / 1ps

// Priority request queue.
// Input channel req_*: one item is either a put (store handle, client task and
// priority) or a get (remove the stored entry with the largest priority, the
// oldest one on a tie; priority 0 is never served). Each item yields exactly
// one result item on rsp_*, carrying status, the server wake for a put, the
// removed entry for a get and the entry count after the operation.
// csr_write_enable/csr_write_data load the server task id woken on each successful put.
// Entries live in a 16-entry RAM in insertion order, oldest at address 0.
// Timing:
//   put, and get on an empty queue: result registered at the accept edge; a new
//   item may follow on the next cycle if the receiver does not hold rsp_stall.
//   get on n stored entries: the RAM is scanned, one read per cycle, then the
//   gap behind the removed slot p is closed up, one read and one write-back per
//   cycle; the single RAM read port sets this rate.
// Only one item is in flight; req_stall is high while a get is working, and
// also while a finished result sits in the output register and the receiver
// holds rsp_stall. A stalled result holds its value until taken.
// Reset (synchronous, active high) empties the queue and clears server task
// and the output valid flag; RAM contents and the output item are not cleared.
module priority_request_queue_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  prq_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output prq_pkg::rsp_item_type rsp_item,
   input  logic                  csr_write_enable,
   input  logic [7:0]            csr_write_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT
   } state_type;

   state_type             state_ff, state_in;
   prq_pkg::count_type    count_ff, count_in;
   logic [7:0]            server_task_ff, server_task_in;
   prq_pkg::addr_type     rd_idx_ff, rd_idx_in;
   logic [7:0]            best_prio_ff, best_prio_in;
   prq_pkg::addr_type     best_pos_ff, best_pos_in;
   prq_pkg::entry_type    best_entry_ff, best_entry_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   prq_pkg::rsp_item_type rsp_item_ff, rsp_item_in;

   // RAM port signals
   logic                  ram_wr_en;
   prq_pkg::addr_type     ram_wr_addr;
   prq_pkg::entry_type    ram_wr_data;
   logic                  ram_rd_en;
   prq_pkg::addr_type     ram_rd_addr;
   logic [prq_pkg::ENTRY_W-1:0] ram_rd_raw;
   prq_pkg::entry_type    ram_rd_data;

   logic                  out_free;
   logic                  accept;
   logic                  at_last;
   prq_pkg::count_type    last_cnt;
   prq_pkg::count_type    count_dec;
   logic [7:0]            cur_prio;
   prq_pkg::addr_type     cur_pos;
   prq_pkg::entry_type    cur_entry;

   prq_ram #(
      .WIDTH (prq_pkg::ENTRY_W),
      .DEPTH (prq_pkg::QUEUE_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_raw)
   );

   assign ram_rd_data = prq_pkg::entry_type'(ram_rd_raw);

   // The output register is free when empty or being taken this cycle.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;

   assign last_cnt  = count_ff - prq_pkg::count_type'(1);
   assign count_dec = count_ff - prq_pkg::count_type'(1);
   assign at_last   = (prq_pkg::count_type'(rd_idx_ff) == last_cnt);

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      server_task_in = server_task_ff;
      rd_idx_in      = rd_idx_ff;
      best_prio_in   = best_prio_ff;
      best_pos_in    = best_pos_ff;
      best_entry_in  = best_entry_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_item_in    = rsp_item_ff;

      ram_wr_en   = 1'b0;
      ram_wr_addr = '0;
      ram_wr_data = '0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = '0;

      // Running maximum including the entry read back this cycle; strict
      // compare keeps the oldest entry on a tie.
      cur_prio  = best_prio_ff;
      cur_pos   = best_pos_ff;
      cur_entry = best_entry_ff;
      if (ram_rd_data.prio > best_prio_ff) begin
         cur_prio  = ram_rd_data.prio;
         cur_pos   = rd_idx_ff;
         cur_entry = ram_rd_data;
      end

      if (csr_write_enable) begin
         server_task_in = csr_write_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = '0;
               if (req_item.func == prq_pkg::FUNC_PUT) begin
                  if (count_ff == prq_pkg::count_type'(prq_pkg::QUEUE_DEPTH)) begin
                     // Drop the item: queue is full.
                     rsp_item_in.status    = prq_pkg::STATUS_FULL;
                     rsp_item_in.remaining = prq_pkg::to_remaining(count_ff);
                  end else begin
                     ram_wr_en               = 1'b1;
                     ram_wr_addr             = prq_pkg::addr_type'(count_ff);
                     ram_wr_data.prio        = req_item.priority_req;
                     ram_wr_data.client_task = req_item.client_task;
                     ram_wr_data.handle      = req_item.req_handle;
                     count_in                = count_ff + prq_pkg::count_type'(1);
                     rsp_item_in.status      = prq_pkg::STATUS_OK;
                     rsp_item_in.wake_server = 1'b1;
                     rsp_item_in.wake_task   = server_task_ff;
                     rsp_item_in.remaining   =
                        prq_pkg::to_remaining(count_ff + prq_pkg::count_type'(1));
                  end
               end else if (count_ff == '0) begin
                  rsp_item_in.status    = prq_pkg::STATUS_EMPTY;
                  rsp_item_in.remaining = prq_pkg::to_remaining(count_ff);
               end else begin
                  // Start the scan at the oldest entry.
                  rsp_valid_in = 1'b0;
                  ram_rd_en    = 1'b1;
                  ram_rd_addr  = '0;
                  rd_idx_in    = '0;
                  best_prio_in = '0;
                  best_pos_in  = '0;
                  state_in     = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            best_prio_in  = cur_prio;
            best_pos_in   = cur_pos;
            best_entry_in = cur_entry;
            if (!at_last) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = prq_pkg::addr_type'(rd_idx_ff + prq_pkg::addr_type'(1));
               rd_idx_in   = prq_pkg::addr_type'(rd_idx_ff + prq_pkg::addr_type'(1));
            end else if (cur_prio == '0) begin
               // Nothing eligible: leave the queue untouched.
               rsp_valid_in          = 1'b1;
               rsp_item_in           = '0;
               rsp_item_in.status    = prq_pkg::STATUS_NONE;
               rsp_item_in.remaining = prq_pkg::to_remaining(count_ff);
               state_in              = ST_IDLE;
            end else if (prq_pkg::count_type'(cur_pos) == last_cnt) begin
               // Newest entry removed: no gap to close.
               count_in                   = count_dec;
               rsp_valid_in               = 1'b1;
               rsp_item_in                = '0;
               rsp_item_in.status         = prq_pkg::STATUS_OK;
               rsp_item_in.out_req_handle = cur_entry.handle;
               rsp_item_in.out_task       = cur_entry.client_task;
               rsp_item_in.out_priority   = cur_entry.prio;
               rsp_item_in.remaining      = prq_pkg::to_remaining(count_dec);
               state_in                   = ST_IDLE;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = prq_pkg::addr_type'(cur_pos + prq_pkg::addr_type'(1));
               rd_idx_in   = prq_pkg::addr_type'(cur_pos + prq_pkg::addr_type'(1));
               state_in    = ST_SHIFT;
            end
         end

         ST_SHIFT: begin
            // Move the entry just read down by one slot.
            ram_wr_en   = 1'b1;
            ram_wr_addr = prq_pkg::addr_type'(rd_idx_ff - prq_pkg::addr_type'(1));
            ram_wr_data = ram_rd_data;
            if (!at_last) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = prq_pkg::addr_type'(rd_idx_ff + prq_pkg::addr_type'(1));
               rd_idx_in   = prq_pkg::addr_type'(rd_idx_ff + prq_pkg::addr_type'(1));
            end else begin
               count_in                   = count_dec;
               rsp_valid_in               = 1'b1;
               rsp_item_in                = '0;
               rsp_item_in.status         = prq_pkg::STATUS_OK;
               rsp_item_in.out_req_handle = best_entry_ff.handle;
               rsp_item_in.out_task       = best_entry_ff.client_task;
               rsp_item_in.out_priority   = best_entry_ff.prio;
               rsp_item_in.remaining      = prq_pkg::to_remaining(count_dec);
               state_in                   = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         count_ff       <= '0;
         server_task_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         server_task_ff <= server_task_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rd_idx_ff     <= rd_idx_in;
      best_prio_ff  <= best_prio_in;
      best_pos_ff   <= best_pos_in;
      best_entry_ff <= best_entry_in;
      rsp_item_ff   <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // Count never exceeds the queue depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= prq_pkg::count_type'(prq_pkg::QUEUE_DEPTH))
      else $error("entry count above queue depth");

   // While a get works, the output register is already empty.
   a_out_free_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !rsp_valid_ff)
      else $error("output register occupied during get");

   // A shift pass only follows a scan that found an eligible entry.
   a_shift_eligible: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SHIFT |-> best_prio_ff != '0)
      else $error("shift without eligible entry");

   // A scan read never runs past the stored entries.
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> prq_pkg::count_type'(rd_idx_ff) < count_ff)
      else $error("scan index beyond entry count");

   // A wake is only reported with a successful put.
   a_wake_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.wake_server |->
         rsp_item_ff.status == prq_pkg::STATUS_OK && rsp_item_ff.out_priority == '0)
      else $error("wake reported without successful put");

endmodule

/* sv/prq_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module prq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
